### rtl/bra_pkg.sv
`timescale 1ns / 1ps

package bra_pkg;

  // Store geometry: bytes of eight allocation bits each.
  localparam int unsigned MaxBytes = 128;
  localparam int unsigned AddrW    = $clog2(MaxBytes);
  localparam int unsigned EffW     = $clog2(MaxBytes + 1);
  localparam int unsigned CntW     = $clog2(MaxBytes * 8 + 1);

  // Fixed field widths of the beats.
  localparam int unsigned LenW     = 8;
  localparam int unsigned IdxW     = 10;
  localparam int unsigned RunW     = 11;

  // Operation codes carried on the input tuser.
  typedef enum logic [1:0] {
    FUNC_TEST  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_SCAN  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_e;

  // Access request from the controller to the bitmap store.
  typedef struct packed {
    logic [AddrW-1:0] rd_addr;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             clr;
  } mem_req_t;

endpackage

### rtl/bra_store.sv
`timescale 1ns / 1ps

module bra_store import bra_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  mem_req_t   req_i,
  output logic [7:0] rd_data_o
);

  logic [7:0]          mem_q [MaxBytes];
  logic [MaxBytes-1:0] vld_q;
  logic [7:0]          rd_data_q;
  logic                rd_vld_q;

  // Byte array with one synchronous read port and one write port.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    rd_data_q <= mem_q[req_i.rd_addr];
    rd_vld_q  <= vld_q[req_i.rd_addr];
  end

  // One valid bit per byte; reset and clear empty the whole store at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.clr) begin
      vld_q <= '0;
    end else if (req_i.wr_en) begin
      vld_q[req_i.wr_addr] <= 1'b1;
    end
  end

  // A byte never written since the last clear reads as all zeros.
  assign rd_data_o = rd_vld_q ? rd_data_q : 8'h00;

endmodule

### rtl/bitmap_run_allocator_top.sv
`timescale 1ns / 1ps
// Channel  | Dir | Signals                         | Payload (lowest bit first)
// s_axis   | in  | tvalid tready tdata[23:0] tuser | tdata: bit_index, bit_value, run_length
//          |     |                                 | tuser: func
// m_axis   | out | tvalid tready tdata[15:0]       | tdata: found, start_index, bit_state
// cfg      | in  | cfg_valid_i cfg_ready_o         | cfg_data_i: length_in_bytes
//
// Test and write pass through ST_BIT and then ST_RESP before the next beat is accepted
// (an index out of use goes straight to ST_RESP); clear goes straight to ST_RESP.
// Scan reads one store byte per cycle through the single read port, over at most the
// N bytes in use (N at most 128), ending early at the first fitting run.
// After reset the store reads as all zeros at once and the length is 128 bytes.
// One result waits in the output register while the next beat is taken; a further
// result holds in the controller until the output register frees.

module bitmap_run_allocator_top import bra_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // bit_index[9:0], bit_value[10], run_length[21:11]
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // found[0], start_index[10:1], bit_state[11]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_BIT  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_RESP = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  func_e             func_q, func_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              val_q, val_d;
  logic [RunW-1:0]   run_q, run_d;
  logic [AddrW-1:0]  ptr_q, ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [LenW-1:0]   len_q;
  logic              res_found_q, res_found_d;
  logic [IdxW-1:0]   res_start_q, res_start_d;
  logic              res_bit_q, res_bit_d;
  logic              out_valid_q, out_valid_d;
  logic              out_found_q;
  logic [IdxW-1:0]   out_start_q;
  logic              out_bit_q;

  logic              in_fire;
  logic              out_load;
  func_e             in_func;
  logic [IdxW-1:0]   in_idx;
  logic              in_val;
  logic [RunW-1:0]   in_run;
  logic [EffW-1:0]   eff_len;
  logic [CntW-1:0]   bits_used;
  logic              idx_in_use;
  logic              last_byte;
  mem_req_t          mem_req;
  logic [7:0]        rd_byte;
  logic [7:0]        bit_mask;
  logic [CntW-1:0]   scan_cnt;
  logic              scan_hit;
  logic [2:0]        hit_pos;
  logic [CntW-1:0]   start_sum;

  // Unpack the input beat.
  assign in_func = func_e'(s_axis_tuser);
  assign in_idx  = s_axis_tdata[IdxW-1:0];
  assign in_val  = s_axis_tdata[IdxW];
  assign in_run  = s_axis_tdata[IdxW+1 +: RunW];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Bytes in use, saturated to the store size, and the bit count they span.
  assign eff_len    = (len_q > LenW'(MaxBytes)) ? EffW'(MaxBytes) : EffW'(len_q);
  assign bits_used  = {eff_len, 3'b000};
  assign idx_in_use = ({1'b0, in_idx} < bits_used);
  assign last_byte  = ({1'b0, ptr_q} == (eff_len - EffW'(1)));

  // Length register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenW'(MaxBytes);
    end else if (cfg_valid_i && cfg_ready_o) begin
      len_q <= cfg_data_i;
    end
  end

  // Walk the bits of one scanned byte from the lowest, carrying the run count.
  always_comb begin
    scan_cnt = cnt_q;
    scan_hit = 1'b0;
    hit_pos  = 3'd0;
    for (int b = 0; b < 8; b++) begin
      if (!scan_hit) begin
        if (rd_byte[b]) begin
          scan_cnt = '0;
        end else begin
          scan_cnt = scan_cnt + CntW'(1);
        end
        if (scan_cnt == run_q) begin
          scan_hit = 1'b1;
          hit_pos  = 3'(b);
        end
      end
    end
  end

  // Start of the run that ends at the hit bit.
  assign start_sum = {1'b0, ptr_q, hit_pos} + CntW'(1) - run_q;
  assign bit_mask  = 8'h01 << idx_q[2:0];

  // Store accesses: read address is presented in the cycle before its data is used.
  always_comb begin
    mem_req         = '0;
    mem_req.rd_addr = (in_func == FUNC_SCAN) ? '0 : in_idx[IdxW-1 -: AddrW];
    if (state_q == ST_SCAN) begin
      mem_req.rd_addr = ptr_q + AddrW'(1);
    end
    mem_req.clr     = in_fire && (in_func == FUNC_CLEAR);
    mem_req.wr_en   = (state_q == ST_BIT) && (func_q == FUNC_WRITE);
    mem_req.wr_addr = idx_q[IdxW-1 -: AddrW];
    mem_req.wr_data = val_q ? (rd_byte | bit_mask) : (rd_byte & ~bit_mask);
  end

  bra_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (rd_byte)
  );

  assign out_load = (state_q == ST_RESP) && (!out_valid_q || m_axis_tready);

  // Controller.
  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    idx_d       = idx_q;
    val_d       = val_q;
    run_d       = run_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    res_found_d = res_found_q;
    res_start_d = res_start_q;
    res_bit_d   = res_bit_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          func_d      = in_func;
          idx_d       = in_idx;
          val_d       = in_val;
          run_d       = in_run;
          ptr_d       = '0;
          cnt_d       = '0;
          res_found_d = 1'b0;
          res_start_d = '0;
          res_bit_d   = 1'b0;
          case (in_func)
            FUNC_TEST, FUNC_WRITE: begin
              state_d = idx_in_use ? ST_BIT : ST_RESP;
            end
            FUNC_SCAN: begin
              // An empty run or no bytes in use cannot be found.
              state_d = ((in_run == '0) || (eff_len == '0)) ? ST_RESP : ST_SCAN;
            end
            default: begin
              res_found_d = 1'b1;
              state_d     = ST_RESP;
            end
          endcase
        end
      end
      ST_BIT: begin
        res_found_d = 1'b1;
        res_bit_d   = (func_q == FUNC_TEST) ? rd_byte[idx_q[2:0]] : 1'b0;
        state_d     = ST_RESP;
      end
      ST_SCAN: begin
        cnt_d = scan_cnt;
        ptr_d = ptr_q + AddrW'(1);
        if (scan_hit) begin
          res_found_d = 1'b1;
          res_start_d = start_sum[IdxW-1:0];
          state_d     = ST_RESP;
        end else if (last_byte) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ptr_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    idx_q       <= idx_d;
    val_q       <= val_d;
    run_q       <= run_d;
    res_found_q <= res_found_d;
    res_start_q <= res_start_d;
    res_bit_q   <= res_bit_d;
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_found_q <= res_found_q;
      out_start_q <= res_start_q;
      out_bit_q   <= res_bit_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_bit_q, out_start_q, out_found_q};

  // The store is written only while a write beat is being completed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.wr_en |-> (state_q == ST_BIT) && (func_q == FUNC_WRITE))
    else $error("store written outside a bit write");

  // The scan pointer never goes beyond the bytes in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> ({1'b0, ptr_q} < eff_len))
    else $error("scan pointer beyond bytes in use");

  // A result waiting on a stalled output stays in the controller.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP) && out_valid_q && !m_axis_tready |=> (state_q == ST_RESP))
    else $error("result dropped while output stalled");

  // A set tested bit always comes with found and a zero start index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_bit_q |-> out_found_q && (out_start_q == '0))
    else $error("bit state reported without found");

endmodule

### bench/bitmap_alloc_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and length channels of the allocator, keeps its
// own copy of the bitmap, and compares every result beat with the oldest
// prediction still waiting.
module bitmap_alloc_checker import bra_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // bit_index[9:0], bit_value[10], run_length[21:11]
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // found[0], start_index[10:1], bit_state[11]
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  output int          fail_cnt_o,
  output int          pending_cnt_o
);

  typedef struct packed {
    logic            bit_state;
    logic [IdxW-1:0] start_index;
    logic            found;
  } alloc_res_t;

  logic [7:0]      alloc_map [MaxBytes];
  logic [LenW-1:0] map_len;
  alloc_res_t      pending_alloc_results [$];
  int              fail_cnt;

  // Applies one request to the local bitmap and returns the answer it must give.
  function automatic alloc_res_t predict_alloc_result(func_e op, logic [IdxW-1:0] idx,
                                                      logic val, logic [RunW-1:0] run);
    alloc_res_t  res;
    int unsigned used;
    int unsigned zeros;
    int unsigned pos;
    res  = '0;
    used = ((map_len > MaxBytes) ? MaxBytes : map_len) * 8;
    case (op)
      FUNC_TEST: begin
        if (idx < used) begin
          res.found     = 1'b1;
          res.bit_state = alloc_map[idx >> 3][idx[2:0]];
        end
      end
      FUNC_WRITE: begin
        if (idx < used) begin
          res.found                       = 1'b1;
          alloc_map[idx >> 3][idx[2:0]] = val;
        end
      end
      FUNC_SCAN: begin
        // First fit: the run must end inside the bits in use.
        if (run != 0 && run <= used) begin
          zeros = 0;
          pos   = 0;
          while (pos < used && !res.found) begin
            if (alloc_map[pos >> 3][pos % 8]) zeros = 0;
            else zeros++;
            if (zeros == run) begin
              res.found       = 1'b1;
              res.start_index = IdxW'(pos + 1 - run);
            end
            pos++;
          end
        end
      end
      default: begin
        // Clear reaches every byte, also those beyond the length in use.
        foreach (alloc_map[b]) alloc_map[b] = 8'h00;
        res.found = 1'b1;
      end
    endcase
    return res;
  endfunction

  // Results are taken before new requests, since a result at the same edge
  // always belongs to an older request.
  always @(posedge clk_i or negedge rst_ni) begin
    alloc_res_t exp_res;
    alloc_res_t got_res;
    if (!rst_ni) begin
      foreach (alloc_map[b]) alloc_map[b] = 8'h00;
      map_len = LenW'(MaxBytes);
      pending_alloc_results.delete();
      fail_cnt = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) map_len = cfg_data_i;

      if (m_axis_tvalid && m_axis_tready) begin
        got_res = m_axis_tdata[11:0];
        if (pending_alloc_results.size() == 0) begin
          $error("result beat %h with no request outstanding", m_axis_tdata);
          fail_cnt++;
        end else begin
          exp_res = pending_alloc_results.pop_front();
          if (got_res.found !== exp_res.found) begin
            $error("found: expected %0d, got %0d", exp_res.found, got_res.found);
            fail_cnt++;
          end
          if (got_res.start_index !== exp_res.start_index) begin
            $error("start_index: expected %0d, got %0d",
                   exp_res.start_index, got_res.start_index);
            fail_cnt++;
          end
          if (got_res.bit_state !== exp_res.bit_state) begin
            $error("bit_state: expected %0d, got %0d", exp_res.bit_state, got_res.bit_state);
            fail_cnt++;
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        pending_alloc_results.push_back(predict_alloc_result(func_e'(s_axis_tuser),
            s_axis_tdata[9:0], s_axis_tdata[10], s_axis_tdata[21:11]));
      end
    end
    fail_cnt_o    <= fail_cnt;
    pending_cnt_o <= pending_alloc_results.size();
  end

endmodule

### bench/bitmap_run_allocator_top_tb.sv
`timescale 1ns / 1ps

module bitmap_run_allocator_top_tb;
  import bra_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int LongHold   = 400;
  localparam int TailCycles = 150;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // bit_index[9:0], bit_value[10], run_length[21:11]
  logic [1:0]  s_axis_tuser  = FUNC_TEST;   // func[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;   // found[0], start_index[10:1], bit_state[11]
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i    = '0;

  int fail_cnt;
  int pending_cnt;
  int cycle_cnt          = 0;
  int long_holds_wanted  = 0;
  int long_holds_done    = 0;
  bit tx_gappy           = 1'b0;
  bit rx_stalls          = 1'b0;
  int burst_left         = 0;
  int unsigned used_bits = MaxBytes * 8;

  always #1 clk_i = ~clk_i;

  bitmap_run_allocator_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  bitmap_alloc_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .fail_cnt_o    (fail_cnt),
    .pending_cnt_o (pending_cnt)
  );

  // Result side: ready on and off in runs of its own, or a long hold on request.
  initial begin : rx_pacing
    bit rx_on;
    int rx_left;
    rx_on   = 1'b1;
    rx_left = 0;
    forever begin
      @(posedge clk_i);
      if (long_holds_wanted != long_holds_done) begin
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        long_holds_done++;
        m_axis_tready <= 1'b1;
      end else if (rx_stalls) begin
        if (rx_left == 0) begin
          rx_on   = !rx_on;
          rx_left = rx_on ? $urandom_range(1, 8) : $urandom_range(1, 5);
        end
        rx_left--;
        m_axis_tready <= rx_on;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Runaway guard.
  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("simulation failed");
    $finish;
  end

  // Offers one request beat and returns at the edge that takes it.
  task automatic send_request(func_e op, int idx, bit val, int run);
    int gap;
    if (tx_gappy) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap        = $urandom_range(1, 10);
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, RunW'(run), val, IdxW'(idx)};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stops offering and waits until every outstanding result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
  endtask

  // Length writes only happen with the allocator idle.
  task automatic set_length(int len);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= 8'(len);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    used_bits = ((len > MaxBytes) ? MaxBytes : len) * 8;
  endtask

  // Random index, mostly inside a small window so that scans meet set bits.
  function automatic int pick_index();
    int r;
    r = $urandom_range(0, 99);
    if (used_bits == 0 || r < 8) return $urandom_range(0, 1023);
    if (r < 75) return $urandom_range(0, ((used_bits < 48) ? used_bits : 48) - 1);
    return $urandom_range(0, used_bits - 1);
  endfunction

  // Random run length, mostly short, now and then degenerate or too long.
  function automatic int pick_run();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 24);
    if (r < 75 && used_bits > 0) return $urandom_range(1, used_bits);
    if (r < 80) return 0;
    if (r < 85) return (used_bits < 1024) ? used_bits + 1 : 1024;
    if (r < 90) return 1024;
    return $urandom_range(0, 1024);
  endfunction

  task automatic random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) send_request(FUNC_WRITE, pick_index(), ($urandom_range(0, 3) != 0), 0);
    else if (r < 60) send_request(FUNC_TEST, pick_index(), $urandom_range(0, 1), 0);
    else if (r < 97) send_request(FUNC_SCAN, $urandom_range(0, 1023), 0, pick_run());
    else send_request(FUNC_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1), 0);
  endtask

  initial begin : stimulus
    int phase_len [11];
    phase_len = '{128, 1, 37, 128, 0, 2, 64, 255, 16, 128, 100};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single bits at both ends of the full map.
    send_request(FUNC_TEST,  0,    0, 0);
    send_request(FUNC_WRITE, 0,    1, 0);
    send_request(FUNC_TEST,  0,    0, 0);
    send_request(FUNC_WRITE, 1023, 1, 0);
    send_request(FUNC_TEST,  1023, 0, 0);
    send_request(FUNC_WRITE, 1023, 0, 0);
    send_request(FUNC_TEST,  1023, 1, 0);
    // Zero run, shortest run, and a full-length run blocked by bit 0.
    send_request(FUNC_SCAN,  0, 0, 0);
    send_request(FUNC_SCAN,  0, 0, 1);
    send_request(FUNC_SCAN,  0, 0, 1024);
    send_request(FUNC_CLEAR, 0, 0, 0);
    send_request(FUNC_SCAN,  0, 0, 1024);
    // One set bit in the middle splits the map into two free runs.
    send_request(FUNC_WRITE, 512, 1, 0);
    send_request(FUNC_SCAN,  0,   0, 600);
    send_request(FUNC_SCAN,  0,   0, 512);
    send_request(FUNC_WRITE, 5,   1, 0);
    send_request(FUNC_SCAN,  0,   0, 510);
    send_request(FUNC_WRITE, 100, 1, 0);

    // One byte in use: indexes past it are refused, long runs do not fit.
    set_length(1);
    send_request(FUNC_TEST,  8, 0, 0);
    send_request(FUNC_WRITE, 8, 1, 0);
    send_request(FUNC_SCAN,  0, 0, 9);
    // Clear also wipes bytes beyond the length in use.
    send_request(FUNC_CLEAR, 0, 0, 0);
    // No bytes in use.
    set_length(0);
    send_request(FUNC_TEST, 0, 0, 0);
    send_request(FUNC_SCAN, 0, 0, 1);
    // A length above the store saturates.
    set_length(200);
    send_request(FUNC_TEST, 100,  0, 0);
    send_request(FUNC_TEST, 1023, 0, 0);

    // Random phases over a spread of lengths and pacing.
    foreach (phase_len[p]) begin
      set_length(phase_len[p]);
      tx_gappy   = (p != 0) && ($urandom_range(0, 3) != 0);
      rx_stalls  = (p != 0) && ($urandom_range(0, 3) != 0);
      burst_left = 0;
      if (p == 3) begin
        // Results back up while requests keep coming.
        tx_gappy  = 1'b0;
        long_holds_wanted++;
      end
      for (int n = 0; n < 60; n++) begin
        if (n == 30 && $urandom_range(0, 1)) drain_results();
        random_request();
      end
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/bra_pkg.sv
rtl/bra_store.sv
rtl/bitmap_run_allocator_top.sv
bench/bitmap_alloc_checker.sv
bench/bitmap_run_allocator_top_tb.sv
